FILE: rtl/midi_rpn_nrpn_receive_decoder_macros.svh
`ifndef MIDI_RPN_NRPN_RECEIVE_DECODER_MACROS_SVH
`define MIDI_RPN_NRPN_RECEIVE_DECODER_MACROS_SVH

// Concurrent assertion on clk_i, off while rst_ni is low.
`define MRND_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication on clk_i, off while rst_ni is low.
`define MRND_ASSERT_IMPL(label, ante, cons, msg) \
  `MRND_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication on clk_i, off while rst_ni is low.
`define MRND_ASSERT_NEXT(label, ante, cons, msg) \
  `MRND_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/mrnd_pkg.sv
`default_nettype none

package mrnd_pkg;

  localparam int unsigned ChW        = 4;
  localparam int unsigned CcW        = 7;
  localparam int unsigned ValW       = 7;
  localparam int unsigned NumW       = 14;
  localparam int unsigned DefNumChan = 16;

  localparam logic [CcW-1:0]  CC_RPN_MSB  = 7'd101;
  localparam logic [CcW-1:0]  CC_RPN_LSB  = 7'd100;
  localparam logic [CcW-1:0]  CC_NRPN_MSB = 7'd99;
  localparam logic [CcW-1:0]  CC_NRPN_LSB = 7'd98;
  localparam logic [CcW-1:0]  CC_DATA_MSB = 7'd6;
  localparam logic [CcW-1:0]  CC_DATA_LSB = 7'd38;
  localparam logic [ValW-1:0] RPN_NULL    = 7'h7F;

  typedef struct packed {
    logic [ChW-1:0]  midi_channel_num;
    logic [CcW-1:0]  controller_num;
    logic [ValW-1:0] data_value;
  } midi_cc_t;

  typedef struct packed {
    logic            is_nrpn;
    logic [ChW-1:0]  out_channel;
    logic [NumW-1:0] parameter_number;
    logic [NumW-1:0] parameter_value;
  } param_upd_t;

  typedef struct packed {
    logic            mode_nrpn;
    logic            addr_low_vld;
    logic            addr_high_vld;
    logic            val_high_pend;
    logic [NumW-1:0] param_num;
    logic [ValW-1:0] val_high;
  } chan_state_t;

  typedef struct packed {
    logic           en;
    logic [ChW-1:0] addr;
  } mem_wr_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/mrnd_state_mem.sv
`default_nettype none

module mrnd_state_mem
  import mrnd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = DefNumChan
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_en_i,
  input  logic [ChW-1:0] rd_addr_i,
  input  mem_wr_ctl_t    wr_ctl_i,
  input  chan_state_t    wr_data_i,
  output chan_state_t    rd_data_o
);

  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  chan_state_t             mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  chan_state_t             rd_q;
  chan_state_t             fwd_data_q;
  logic                    rd_vld_q;
  logic                    fwd_q;
  logic [AW-1:0]           rd_idx;
  logic [AW-1:0]           wr_idx;

  assign rd_idx = rd_addr_i[AW-1:0];
  assign wr_idx = wr_ctl_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.en) begin
      mem_q[wr_idx] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_idx];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_ctl_i.en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx];
        fwd_q    <= wr_ctl_i.en && (wr_ctl_i.addr == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);

endmodule

`default_nettype wire

FILE: rtl/mrnd_update.sv
`default_nettype none

module mrnd_update
  import mrnd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = DefNumChan
) (
  input  midi_cc_t    item_i,
  input  chan_state_t state_i,
  output chan_state_t state_o,
  output logic        wr_en_o,
  output logic        upd_vld_o,
  output param_upd_t  upd_o
);

  logic        in_range;
  logic        rpn_addr;
  logic        nrpn_addr;
  logic [CcW-1:0]  cc;
  logic [ValW-1:0] v;
  chan_state_t nxt;

  assign cc        = item_i.controller_num;
  assign v         = item_i.data_value;
  assign in_range  = {1'b0, item_i.midi_channel_num} < (ChW+1)'(NUM_CHANNELS);
  assign rpn_addr  = (cc == CC_RPN_MSB) || (cc == CC_RPN_LSB);
  assign nrpn_addr = (cc == CC_NRPN_MSB) || (cc == CC_NRPN_LSB);

  always_comb begin
    nxt = state_i;
    if ((nxt.mode_nrpn && rpn_addr) || (!nxt.mode_nrpn && nrpn_addr)) begin
      nxt.mode_nrpn     = 1'b0;
      nxt.addr_low_vld  = 1'b0;
      nxt.addr_high_vld = 1'b0;
    end
    if (rpn_addr || nrpn_addr) begin
      nxt.val_high_pend = 1'b0;
    end
    if ((cc == CC_RPN_MSB) || (cc == CC_NRPN_MSB)) begin
      nxt.param_num[NumW-1:ValW] = v;
      nxt.addr_high_vld          = !((cc == CC_RPN_MSB) && (v == RPN_NULL));
      if (cc == CC_NRPN_MSB) begin
        nxt.mode_nrpn = 1'b1;
      end
    end
    if ((cc == CC_RPN_LSB) || (cc == CC_NRPN_LSB)) begin
      nxt.param_num[ValW-1:0] = v;
      nxt.addr_low_vld        = !((cc == CC_RPN_LSB) && (v == RPN_NULL));
      if (cc == CC_NRPN_LSB) begin
        nxt.mode_nrpn = 1'b1;
      end
    end
    if ((cc == CC_DATA_MSB) && nxt.addr_high_vld && nxt.addr_low_vld) begin
      nxt.val_high      = v;
      nxt.val_high_pend = 1'b1;
    end
    upd_vld_o = in_range && (cc == CC_DATA_LSB) && nxt.val_high_pend;
    if ((cc == CC_DATA_LSB) && nxt.val_high_pend) begin
      nxt.val_high_pend = 1'b0;
    end
  end

  assign state_o                = nxt;
  assign wr_en_o                = in_range;
  assign upd_o.is_nrpn          = nxt.mode_nrpn;
  assign upd_o.out_channel      = item_i.midi_channel_num;
  assign upd_o.parameter_number = nxt.param_num;
  assign upd_o.parameter_value  = {state_i.val_high, v};

endmodule

`default_nettype wire

FILE: rtl/midi_rpn_nrpn_receive_decoder.sv
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+--------------------------
// in      | input     | in_valid_i / in_ready_o | in_data_i  (midi_cc_t)
// out     | output    | out_valid_o/out_ready_i | out_data_o (param_upd_t)
//
// One transaction per cycle unless the output stalls; a result passes the s1 stage, then the output register.
// Per-channel state sits in one NUM_CHANNELS-entry (default 16) memory with a registered read;
// a write to the channel being read in the same cycle is forwarded.
// Reset clears the per-entry valid bits at once; no clearing pass.
// An output stall holds the update stage, and input stops only when
// both the update stage and the output register are full.
`default_nettype none

module midi_rpn_nrpn_receive_decoder
  import mrnd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = DefNumChan
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  midi_cc_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output param_upd_t out_data_o
);

  logic        s1_vld_q;
  midi_cc_t    s1_item_q;
  logic        out_vld_q;
  param_upd_t  out_q;
  logic        s1_adv;
  logic        in_acc;
  logic        upd_wr;
  logic        upd_vld;
  param_upd_t  upd;
  chan_state_t cur_state;
  chan_state_t nxt_state;
  mem_wr_ctl_t wr_ctl;

  assign s1_adv     = !out_vld_q || out_ready_i;
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign wr_ctl.en   = s1_vld_q && s1_adv && upd_wr;
  assign wr_ctl.addr = s1_item_q.midi_channel_num;

  mrnd_state_mem #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_acc),
    .rd_addr_i(in_data_i.midi_channel_num),
    .wr_ctl_i (wr_ctl),
    .wr_data_i(nxt_state),
    .rd_data_o(cur_state)
  );

  mrnd_update #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_update (
    .item_i   (s1_item_q),
    .state_i  (cur_state),
    .state_o  (nxt_state),
    .wr_en_o  (upd_wr),
    .upd_vld_o(upd_vld),
    .upd_o    (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_vld_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_vld_q <= s1_vld_q && upd_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_data_i;
    end
    if (s1_adv && s1_vld_q && upd_vld) begin
      out_q <= upd;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/mrnd_checker.sv
`default_nettype none

`include "midi_rpn_nrpn_receive_decoder_macros.svh"

module mrnd_checker
  import mrnd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = DefNumChan
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input midi_cc_t   in_data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input param_upd_t out_data_o
);

  `MRND_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "output transaction dropped or changed while stalled")
  `MRND_ASSERT_IMPL(a_ready_when_free, !out_valid_o, in_ready_o, "input stalled while output side is free")
  `MRND_ASSERT_IMPL(a_chan_range, out_valid_o, {1'b0, out_data_o.out_channel} < (ChW+1)'(NUM_CHANNELS), "update for a channel out of range")
  `MRND_ASSERT_IMPL(a_from_data_lsb, $rose(out_valid_o), $past(in_valid_i && in_ready_o && (in_data_i.controller_num == CC_DATA_LSB), 2), "update without a data entry LSB transaction")

endmodule

bind midi_rpn_nrpn_receive_decoder mrnd_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_mrnd_checker (.*);

`default_nettype wire

FILE: dv/mrnd_update_checker.sv
`default_nettype none

module mrnd_update_checker
  import mrnd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = DefNumChan
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  midi_cc_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  param_upd_t  out_data_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 10;

  logic            mode_nrpn  [NUM_CHANNELS];
  logic            lo_vld     [NUM_CHANNELS];
  logic            hi_vld     [NUM_CHANNELS];
  logic            val_pend   [NUM_CHANNELS];
  logic [NumW-1:0] param_num  [NUM_CHANNELS];
  logic [ValW-1:0] val_high   [NUM_CHANNELS];

  param_upd_t expected_updates[$];

  function automatic bit decode_cc(input midi_cc_t m, output param_upd_t upd);
    logic [ChW-1:0]  ch;
    logic [CcW-1:0]  cc;
    logic [ValW-1:0] v;
    logic            rpn_addr;
    logic            nrpn_addr;
    ch  = m.midi_channel_num;
    cc  = m.controller_num;
    v   = m.data_value;
    upd = '0;
    if (ch >= NUM_CHANNELS) return 1'b0;
    rpn_addr  = (cc == CC_RPN_MSB) || (cc == CC_RPN_LSB);
    nrpn_addr = (cc == CC_NRPN_MSB) || (cc == CC_NRPN_LSB);
    if ((mode_nrpn[ch] && rpn_addr) || (!mode_nrpn[ch] && nrpn_addr)) begin
      mode_nrpn[ch] = 1'b0;
      lo_vld[ch]    = 1'b0;
      hi_vld[ch]    = 1'b0;
    end
    if (rpn_addr || nrpn_addr) val_pend[ch] = 1'b0;
    if (cc == CC_RPN_MSB || cc == CC_NRPN_MSB) begin
      param_num[ch][NumW-1:ValW] = v;
      hi_vld[ch] = !(cc == CC_RPN_MSB && v == RPN_NULL);
      if (cc == CC_NRPN_MSB) mode_nrpn[ch] = 1'b1;
    end
    if (cc == CC_RPN_LSB || cc == CC_NRPN_LSB) begin
      param_num[ch][ValW-1:0] = v;
      lo_vld[ch] = !(cc == CC_RPN_LSB && v == RPN_NULL);
      if (cc == CC_NRPN_LSB) mode_nrpn[ch] = 1'b1;
    end
    if (cc == CC_DATA_MSB && hi_vld[ch] && lo_vld[ch]) begin
      val_high[ch] = v;
      val_pend[ch] = 1'b1;
    end
    if (cc == CC_DATA_LSB && val_pend[ch]) begin
      val_pend[ch]         = 1'b0;
      upd.is_nrpn          = mode_nrpn[ch];
      upd.out_channel      = ch;
      upd.parameter_number = param_num[ch];
      upd.parameter_value  = {val_high[ch], v};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input param_upd_t exp,
                                 input param_upd_t got);
    if (fail_cnt_o < MaxReports) begin
      $display("%0t: %s: exp nrpn=%0b ch=%0d num=%0d val=%0d, got nrpn=%0b ch=%0d num=%0d val=%0d",
               $realtime, what, exp.is_nrpn, exp.out_channel, exp.parameter_number,
               exp.parameter_value, got.is_nrpn, got.out_channel, got.parameter_number,
               got.parameter_value);
    end
    fail_cnt_o <= fail_cnt_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    param_upd_t upd;
    param_upd_t exp;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mode_nrpn[i] = 1'b0;
        lo_vld[i]    = 1'b0;
        hi_vld[i]    = 1'b0;
        val_pend[i]  = 1'b0;
        param_num[i] = '0;
        val_high[i]  = '0;
      end
      expected_updates.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_updates.size() == 0) begin
          report_mismatch("unexpected update", '0, out_data_i);
        end else begin
          exp = expected_updates.pop_front();
          if (out_data_i.is_nrpn !== exp.is_nrpn ||
              out_data_i.out_channel !== exp.out_channel ||
              out_data_i.parameter_number !== exp.parameter_number ||
              out_data_i.parameter_value !== exp.parameter_value) begin
            report_mismatch("update mismatch", exp, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (decode_cc(in_data_i, upd)) expected_updates.push_back(upd);
      end
      pending_o <= expected_updates.size();
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top
  import mrnd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumItems   = 1300;
  localparam int unsigned HoldCycles = 80;
  localparam logic [CcW-1:0] CcVolume = 7'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  midi_cc_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  param_upd_t  out_data;
  int unsigned fail_cnt;
  int unsigned pending;

  bit          stall_req;
  bit          stall_done;
  bit          calm;
  int unsigned n_items;

  always #2 clk_i = ~clk_i;

  midi_rpn_nrpn_receive_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  mrnd_update_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  function automatic logic [ValW-1:0] rand_val();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return RPN_NULL;
    if (pick < 20) return '0;
    return ValW'($urandom_range(127));
  endfunction

  task automatic send_cc(input logic [ChW-1:0] ch, input logic [CcW-1:0] cc,
                         input logic [ValW-1:0] v);
    if (!calm && $urandom_range(99) < 15) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat ($urandom_range(2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= '{ch, cc, v};
    do @(posedge clk_i); while (!in_ready);
    n_items++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic param_sequence(input logic [ChW-1:0] ch);
    logic nrpn;
    nrpn = 1'($urandom_range(1));
    if ($urandom_range(99) < 70) begin
      if ($urandom_range(1)) begin
        send_cc(ch, nrpn ? CC_NRPN_MSB : CC_RPN_MSB, rand_val());
        send_cc(ch, nrpn ? CC_NRPN_LSB : CC_RPN_LSB, rand_val());
      end else begin
        send_cc(ch, nrpn ? CC_NRPN_LSB : CC_RPN_LSB, rand_val());
        send_cc(ch, nrpn ? CC_NRPN_MSB : CC_RPN_MSB, rand_val());
      end
    end
    repeat ($urandom_range(1, 2)) send_cc(ch, CC_DATA_MSB, rand_val());
    send_cc(ch, CC_DATA_LSB, rand_val());
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req && !stall_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        stall_done = 1'b1;
      end
      out_ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  initial begin
    #400us;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    logic [ChW-1:0] ch;
    logic [CcW-1:0] cc;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_cc(0, CC_RPN_MSB, 0);
    send_cc(0, CC_RPN_LSB, 0);
    send_cc(0, CC_DATA_MSB, 127);
    send_cc(0, CC_DATA_LSB, 127);
    send_cc(15, CC_NRPN_MSB, 127);
    send_cc(15, CC_NRPN_LSB, 127);
    send_cc(15, CC_DATA_MSB, 0);
    send_cc(15, CC_DATA_LSB, 0);
    send_cc(1, CC_DATA_LSB, 42);
    send_cc(2, CC_DATA_MSB, 5);
    send_cc(2, CC_DATA_LSB, 6);
    send_cc(0, CC_RPN_MSB, RPN_NULL);
    send_cc(0, CC_DATA_MSB, 1);
    send_cc(0, CC_DATA_LSB, 1);
    send_cc(0, CC_RPN_MSB, 85);
    send_cc(0, CC_DATA_MSB, 10);
    send_cc(0, CC_DATA_MSB, 85);
    send_cc(0, CC_DATA_LSB, 42);
    send_cc(0, CC_NRPN_MSB, 3);
    send_cc(0, CC_DATA_MSB, 7);
    send_cc(0, CC_NRPN_LSB, 4);
    send_cc(15, CC_DATA_MSB, 9);
    send_cc(15, CC_NRPN_MSB, 1);
    send_cc(15, CC_DATA_LSB, 2);
    send_cc(0, CC_RPN_LSB, RPN_NULL);
    send_cc(0, CcVolume, 100);
    drain();

    while (n_items < NumItems) begin
      if (!stall_req && n_items >= 400) begin
        ch = ChW'($urandom_range(15));
        send_cc(ch, CC_NRPN_MSB, rand_val());
        send_cc(ch, CC_NRPN_LSB, rand_val());
        stall_req = 1'b1;
        repeat (30) begin
          send_cc(ch, CC_DATA_MSB, rand_val());
          send_cc(ch, CC_DATA_LSB, rand_val());
        end
        drain();
      end
      calm = (n_items >= 700 && n_items < 900);
      if ($urandom_range(99) < 75) begin
        param_sequence(ChW'($urandom_range(15)));
      end else begin
        case ($urandom_range(6))
          0: cc = CC_RPN_MSB;
          1: cc = CC_RPN_LSB;
          2: cc = CC_NRPN_MSB;
          3: cc = CC_NRPN_LSB;
          4: cc = CC_DATA_MSB;
          5: cc = CC_DATA_LSB;
          default: cc = CcW'($urandom_range(127));
        endcase
        send_cc(ChW'($urandom_range(15)), cc, rand_val());
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
